@@ hdl/iplpc_pkg.sv @@
package iplpc_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  literal_kind;
        logic        is_private;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } t_out_beat;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_V4   = 2'd1;
    localparam logic [1:0] KIND_V6   = 2'd2;

    // Character classes produced by the front end.
    localparam logic [2:0] CC_HEX    = 3'd0;
    localparam logic [2:0] CC_COLON  = 3'd1;
    localparam logic [2:0] CC_DOT    = 3'd2;
    localparam logic [2:0] CC_OTHER  = 3'd3;
    localparam logic [2:0] CC_OPEN   = 3'd4;
    localparam logic [2:0] CC_CLOSE  = 3'd5;

    typedef struct packed {
        logic [2:0] cls;
        logic       is_dec;
        logic [3:0] digit;
        logic       is_last;
        logic       is_first;
    } t_cls_beat;

endpackage

@@ hdl/iplpc_front.sv @@
module iplpc_front
    import iplpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_cls_beat o_data,
    input  logic      i_stall
);
    logic      r_valid;
    t_cls_beat r_data;
    logic      r_first;
    t_cls_beat n_data;
    logic      take;
    logic [7:0] c;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;
    assign c       = i_data.char_code;

    always_comb begin
        n_data          = '0;
        n_data.is_last  = i_data.is_last;
        n_data.is_first = r_first;
        if (c >= 8'h30 && c <= 8'h39) begin
            n_data.cls = CC_HEX; n_data.is_dec = 1'b1; n_data.digit = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            n_data.cls = CC_HEX; n_data.digit = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            n_data.cls = CC_HEX; n_data.digit = 4'(c - 8'h37);
        end else if (c == 8'h3a) begin
            n_data.cls = CC_COLON;
        end else if (c == 8'h2e) begin
            n_data.cls = CC_DOT;
        end else if (c == 8'h5b) begin
            n_data.cls = CC_OPEN;
        end else if (c == 8'h5d) begin
            n_data.cls = CC_CLOSE;
        end else begin
            n_data.cls = CC_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_first <= 1'b1;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_first <= i_data.is_last;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (take) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

@@ hdl/iplpc_queue.sv @@
module iplpc_queue
    import iplpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cls_beat i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_cls_beat o_data,
    input  logic      i_stall
);
    t_cls_beat r_mem [2];
    logic      r_wp, r_rp;
    logic [1:0] r_cnt;
    logic      push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
        if (push) r_mem[r_wp] <= i_data;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |=> r_cnt != 2'd0 || !$past(push))
        else $error("queue count jumped");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue overfull");
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers disagree with count");
`endif
endmodule

@@ hdl/iplpc_back.sv @@
module iplpc_back
    import iplpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cls_beat i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_beat o_data,
    input  logic      i_stall
);
    logic [15:0] r_grp [8];
    logic [3:0]  r_gcnt, n_gcnt;
    logic [3:0]  r_gpos, n_gpos;
    logic        r_gap, n_gap;
    logic [15:0] r_hex, n_hex;
    logic [9:0]  r_dec, n_dec;
    logic [2:0]  r_ndig, n_ndig;
    logic        r_alldec, n_alldec;
    logic [7:0]  r_oct [3];
    logic [2:0]  r_dots, n_dots;
    logic        r_colon, n_colon;
    logic        r_pcol, n_pcol;
    logic        r_brk, n_brk;
    logic        r_fail, n_fail;
    logic        wr_grp, wr_oct;

    logic        r_ovalid;
    t_out_beat   r_out, n_out;
    logic        take;

    // Pieces of the finishing step.
    logic        octet_ok;
    logic [15:0] list   [10];
    logic [15:0] full   [8];
    logic [3:0]  total;
    logic [3:0]  head;
    logic        ok6;
    logic [63:0] hi, lo;
    logic [7:0]  o3;

    assign o_stall = r_ovalid && i_stall;
    assign take    = i_valid && !o_stall;

    function automatic logic [9:0] dec_step(input logic [9:0] v, input logic [3:0] d);
        dec_step = 10'((v << 3) + (v << 1) + {6'd0, d});
    endfunction

    always_comb begin
        logic brk_on;
        logic consume;
        n_gcnt = r_gcnt; n_gpos = r_gpos; n_gap = r_gap; n_hex = r_hex;
        n_dec = r_dec; n_ndig = r_ndig; n_alldec = r_alldec; n_dots = r_dots;
        n_colon = r_colon; n_pcol = r_pcol; n_brk = r_brk; n_fail = r_fail;
        wr_grp = 1'b0; wr_oct = 1'b0;
        brk_on  = i_data.is_first && i_data.cls == CC_OPEN && !i_data.is_last;
        consume = !brk_on && !(i_data.is_last && i_data.cls == CC_CLOSE && r_brk);
        if (brk_on) n_brk = 1'b1;
        if (consume && !r_fail) begin
            case (i_data.cls)
                CC_HEX: begin
                    if (r_pcol && !r_gap && r_gcnt == 4'd0) begin
                        n_fail = 1'b1;
                    end else begin
                        n_pcol = 1'b0;
                        if (r_ndig < 3'd5) n_ndig = 3'(r_ndig + 3'd1);
                        n_hex = {r_hex[11:0], i_data.digit};
                        if (!i_data.is_dec) n_alldec = 1'b0;
                        else if (n_ndig <= 3'd3) n_dec = dec_step(r_dec, i_data.digit);
                    end
                end
                CC_COLON: begin
                    if (r_dots != 3'd0) begin
                        n_fail = 1'b1;
                    end else begin
                        n_colon = 1'b1;
                        if (r_pcol) begin
                            if (r_gap) n_fail = 1'b1;
                            else begin n_gap = 1'b1; n_gpos = r_gcnt; end
                        end else if (r_ndig == 3'd0) begin
                            n_pcol = 1'b1;
                        end else if (r_ndig > 3'd4 || r_gcnt >= 4'd8) begin
                            n_fail = 1'b1;
                        end else begin
                            wr_grp = 1'b1;
                            n_gcnt = 4'(r_gcnt + 4'd1);
                            n_hex = '0; n_dec = '0; n_ndig = '0; n_alldec = 1'b1;
                            n_pcol = 1'b1;
                        end
                    end
                end
                CC_DOT: begin
                    if (!octet_ok || r_dots >= 3'd3) begin
                        n_fail = 1'b1;
                    end else begin
                        wr_oct = 1'b1;
                        n_dots = 3'(r_dots + 3'd1);
                        n_hex = '0; n_dec = '0; n_ndig = '0; n_alldec = 1'b1;
                    end
                end
                default: n_fail = 1'b1;
            endcase
        end
        if (consume && i_data.is_last && r_brk) n_fail = 1'b1;
    end

    assign octet_ok = r_ndig >= 3'd1 && r_ndig <= 3'd3 && r_alldec && r_dec <= 10'd255;

    // Finishing step, evaluated on the state after the last beat.
    always_comb begin
        logic v4;
        logic [7:0] a, b;
        logic [4:0] dst;
        n_out = '0;
        o3    = n_dec[7:0];
        for (int k = 0; k < 8; k++) list[k] = r_grp[k];
        if (wr_grp) list[r_gcnt[2:0]] = r_hex;
        list[8] = '0; list[9] = '0;
        total = n_gcnt;
        ok6 = 1'b1;
        v4  = 1'b0;
        if (n_fail) ok6 = 1'b0;
        else if (n_pcol) begin
            if (!(n_gap && n_gpos == n_gcnt)) ok6 = 1'b0;
        end else if (n_ndig == 3'd0) ok6 = 1'b0;
        else if (n_dots != 3'd0) begin
            if (n_dots != 3'd3 || !(n_ndig <= 3'd3 && n_alldec && n_dec <= 10'd255))
                ok6 = 1'b0;
            else if (!n_colon) begin
                v4 = 1'b1; ok6 = 1'b0;
            end else begin
                if (n_gcnt <= 4'd8) begin
                    list[n_gcnt] = {r_oct[0], r_oct[1]};
                    list[4'(n_gcnt + 4'd1)] = {r_oct[2], o3};
                end
                total = 4'(n_gcnt + 4'd2);
            end
        end else begin
            if (!n_colon || n_ndig > 3'd4) ok6 = 1'b0;
            else begin
                if (n_gcnt <= 4'd8) list[n_gcnt] = n_hex;
                total = 4'(n_gcnt + 4'd1);
            end
        end
        if (n_gap ? total >= 4'd8 : total != 4'd8) ok6 = 1'b0;
        head = n_gap ? n_gpos : total;
        for (int k = 0; k < 8; k++) full[k] = '0;
        for (int k = 0; k < 10; k++) begin
            dst = 5'(5'd8 - {1'b0, total} + 5'(k));
            if (4'(k) < total) begin
                if (4'(k) < head) begin
                    if (k < 8) full[k] = list[k];
                end else if (dst < 5'd8) full[dst[2:0]] = list[k];
            end
        end
        hi = {full[0], full[1], full[2], full[3]};
        lo = {full[4], full[5], full[6], full[7]};
        a = r_oct[0]; b = r_oct[1];
        if (v4) begin
            n_out.literal_kind = KIND_V4;
            n_out.is_private = a == 8'd10 || (a == 8'd172 && b >= 8'd16 && b <= 8'd31)
                || (a == 8'd192 && b == 8'd168) || (a == 8'd169 && b == 8'd254)
                || a == 8'd127;
            n_out.address_low = {32'd0, r_oct[0], r_oct[1], r_oct[2], o3};
        end else if (ok6) begin
            n_out.literal_kind = KIND_V6;
            n_out.address_high = hi;
            n_out.address_low  = lo;
            n_out.is_private = (hi == 64'd0 && lo == 64'd1) || hi[63:56] == 8'hfc
                || hi[63:56] == 8'hfd
                || (hi[63:56] == 8'hfe && (hi[55:48] & 8'hc0) == 8'h80);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcnt <= '0; r_gpos <= '0; r_gap <= 1'b0; r_hex <= '0; r_dec <= '0;
            r_ndig <= '0; r_alldec <= 1'b1; r_dots <= '0; r_colon <= 1'b0;
            r_pcol <= 1'b0; r_brk <= 1'b0; r_fail <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                if (i_data.is_last) begin
                    r_gcnt <= '0; r_gpos <= '0; r_gap <= 1'b0; r_hex <= '0;
                    r_dec <= '0; r_ndig <= '0; r_alldec <= 1'b1; r_dots <= '0;
                    r_colon <= 1'b0; r_pcol <= 1'b0; r_brk <= 1'b0; r_fail <= 1'b0;
                end else begin
                    r_gcnt <= n_gcnt; r_gpos <= n_gpos; r_gap <= n_gap; r_hex <= n_hex;
                    r_dec <= n_dec; r_ndig <= n_ndig; r_alldec <= n_alldec;
                    r_dots <= n_dots; r_colon <= n_colon; r_pcol <= n_pcol;
                    r_brk <= n_brk; r_fail <= n_fail;
                end
            end
            if (take && i_data.is_last) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
        if (take && wr_grp) r_grp[r_gcnt[2:0]] <= r_hex;
        if (take && wr_oct) r_oct[r_dots[1:0]] <= r_dec[7:0];
        if (take && i_data.is_last) r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef NO_ASSERTIONS
    a_gcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gcnt <= 4'd8) else $error("group count past eight");
    a_dots_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dots <= 3'd3) else $error("dot count past three");
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_data.is_last |=> r_gcnt == 4'd0 && !r_fail && !r_brk)
        else $error("state not cleared after last beat");
    a_kind_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.literal_kind == KIND_NONE |-> !r_out.is_private
        && r_out.address_low == 64'd0) else $error("non-literal with payload");
`endif
endmodule

@@ hdl/ip_literal_private_classifier.sv @@
// Address literal classifier: takes a host string one byte per beat and, on
// the beat marked is_last, returns one result beat with the literal kind
// (none, IPv4, IPv6), a private/loopback/link-local flag and the address.
// Outer brackets are stripped; zone ids and any other byte reject the string.
// Throughput is one byte per cycle while neither side stalls; the per-byte
// parse state update in the back end is the loop that sets that figure. The
// result beat passes through the classify register, the queue and the result
// register in turn, the edge that accepts the last byte loading the first.
// Both sides may stall independently; a two-entry queue decouples the byte
// classifier from the parser.
module ip_literal_private_classifier
    import iplpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_beat o_data,
    input  logic      i_stall
);
    logic      f_valid, f_stall, q_valid, q_stall;
    t_cls_beat f_data, q_data;

    // Front: byte to character class and digit value.
    iplpc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .i_data, .o_stall,
        .o_valid(f_valid), .o_data(f_data), .i_stall(f_stall)
    );

    // Short queue between classifier and parser.
    iplpc_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_data(f_data), .o_stall(f_stall),
        .o_valid(q_valid), .o_data(q_data), .i_stall(q_stall)
    );

    // Back: parse state, finishing step and result register.
    iplpc_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_data(q_data), .o_stall(q_stall),
        .o_valid, .o_data, .i_stall
    );
endmodule
